[design/grdfs_pkg.sv]
package grdfs_pkg;

  localparam int FUNC_W   = 2;
  localparam int CITY_W   = 6;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;

  localparam logic [COUNT_W-1:0] CITY_COUNT_RESET = 7'd64;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_ADD   = 2'd1,
    FUNC_QUERY = 2'd2
  } func_t;

  localparam logic [STATUS_W-1:0] ST_ROUTE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_ORIGIN = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_DEST   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NO_ROUTE  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture origin and destination of an accepted item
    logic init;     // start a search: visited, stack and depth
    logic row_wr;   // write the edge-updated adjacency row
    logic clear;    // drop every adjacency row
    logic stage1;   // register the per-group candidate search
    logic push;     // push the picked neighbor
    logic mark;     // mark the picked neighbor visited, stack full
    logic pop;      // drop the top of the stack
    logic pop_top;  // load the new top from the stack memory
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic src_ok;
    logic dst_ok;
    logic top_is_dst;
    logic found;
    logic full;
    logic last;
  } dp_sts_t;

endpackage

[design/grdfs_pick.sv]
module grdfs_pick #(
  parameter int N = 64
) (
  input  logic                                   clk,
  input  logic                                   load,
  input  logic [N-1:0]                           cand,
  output logic                                   found,
  output logic [$clog2(((N + 7) / 8) * 8)-1:0]   idx
);
  localparam int NG = (N + 7) / 8;
  localparam int PW = NG * 8;
  localparam int IW = $clog2(PW);

  logic [PW-1:0] cand_pad;
  logic [NG-1:0] hit_c;
  logic [2:0]    low_c [NG];
  logic [NG-1:0] grp_hit;
  logic [2:0]    grp_low [NG];

  assign cand_pad = PW'(cand);

  // First level: lowest set bit within each group of eight.
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      hit_c[g] = |cand_pad[g*8 +: 8];
      low_c[g] = 3'd0;
      for (int b = 7; b >= 0; b--) begin
        if (cand_pad[g*8 + b]) begin
          low_c[g] = 3'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_hit <= hit_c;
      for (int g = 0; g < NG; g++) begin
        grp_low[g] <= low_c[g];
      end
    end
  end

  // Second level: lowest group that holds a candidate.
  always_comb begin
    found = |grp_hit;
    idx   = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_hit[g]) begin
        idx = IW'(g * 8) | IW'(grp_low[g]);
      end
    end
  end

endmodule

[design/grdfs_datapath.sv]
module grdfs_datapath #(
  parameter int N = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [grdfs_pkg::COUNT_W-1:0]    cfg_data,
  input  logic [grdfs_pkg::CITY_W-1:0]     src_city,
  input  logic [grdfs_pkg::CITY_W-1:0]     dst_city,
  input  grdfs_pkg::dp_cmd_t               cmd,
  output grdfs_pkg::dp_sts_t               sts
);
  import grdfs_pkg::*;

  localparam int NW = $clog2(N);
  localparam int DW = $clog2(N + 1);
  localparam int CW = (NW + 1 > COUNT_W) ? NW + 1 : COUNT_W;
  localparam int IW = $clog2(((N + 7) / 8) * 8);

  logic [COUNT_W-1:0] city_count;
  logic [CW-1:0]      served_n;
  logic [N-1:0]       served_mask;
  logic [N-1:0]       mask_q;

  logic [NW-1:0] src_idx;
  logic [NW-1:0] dst_idx;
  logic [NW-1:0] top;
  logic [NW-1:0] dst_q;
  logic [N-1:0]  visited;
  logic [DW-1:0] depth;
  logic [DW-1:0] depth_m2;

  logic [N-1:0]  adj_mem [N];
  logic [N-1:0]  row_valid;
  logic [N-1:0]  row_q;
  logic          row_vq;
  logic [NW-1:0] rd_addr;
  logic [N-1:0]  dst_oh;
  logic [N-1:0]  src_oh;
  logic [N-1:0]  cand;

  logic [NW-1:0] stk_mem [N];
  logic [NW-1:0] stk_q;

  logic          pk_found;
  logic [IW-1:0] pk_idx;
  logic [NW-1:0] pick_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      city_count <= CITY_COUNT_RESET;
    end else if (cfg_we) begin
      city_count <= cfg_data;
    end
  end

  assign served_n = (CW'(city_count) > CW'(N)) ? CW'(N) : CW'(city_count);

  always_comb begin
    for (int k = 0; k < N; k++) begin
      served_mask[k] = CW'(k) < served_n;
    end
  end

  assign src_idx = NW'(src_city);
  assign dst_idx = NW'(dst_city);
  assign src_oh  = N'(1) << src_idx;
  assign dst_oh  = N'(1) << dst_q;
  assign rd_addr = cmd.load ? src_idx : top;

  // Adjacency rows; a row without its valid bit reads as empty.
  always_ff @(posedge clk) begin
    if (cmd.row_wr) begin
      adj_mem[top] <= (row_vq ? row_q : '0) | dst_oh;
    end
    row_q <= adj_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      row_valid <= '0;
    end else if (cmd.row_wr) begin
      row_valid[top] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    row_vq <= row_valid[rd_addr];
  end

  assign cand = row_q & ~visited & mask_q & {N{row_vq}};

  grdfs_pick #(.N(N)) u_pick (
    .clk   (clk),
    .load  (cmd.stage1),
    .cand  (cand),
    .found (pk_found),
    .idx   (pk_idx)
  );

  assign pick_idx = NW'(pk_idx);

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      mask_q  <= served_mask;
      visited <= src_oh;
    end else if (cmd.push || cmd.mark) begin
      visited[pick_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      top   <= src_idx;
      dst_q <= dst_idx;
    end else if (cmd.push) begin
      top <= pick_idx;
    end else if (cmd.pop_top) begin
      top <= stk_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else if (cmd.init) begin
      depth <= DW'(1);
    end else if (cmd.push) begin
      depth <= depth + DW'(1);
    end else if (cmd.pop) begin
      depth <= depth - DW'(1);
    end
  end

  // The entry below the top is read ahead so a pop can reload the top.
  assign depth_m2 = depth - DW'(2);

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      stk_mem[0] <= src_idx;
    end else if (cmd.push) begin
      stk_mem[depth[NW-1:0]] <= pick_idx;
    end
    stk_q <= stk_mem[depth_m2[NW-1:0]];
  end

  assign sts.src_ok     = CW'(src_city) < served_n;
  assign sts.dst_ok     = CW'(dst_city) < served_n;
  assign sts.top_is_dst = top == dst_q;
  assign sts.found      = pk_found;
  assign sts.full       = depth == DW'(N);
  assign sts.last       = depth == DW'(1);

endmodule

[design/grdfs_ctrl.sv]
module grdfs_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [grdfs_pkg::FUNC_W-1:0]   func,
  input  grdfs_pkg::dp_sts_t             sts,
  output grdfs_pkg::dp_cmd_t             cmd,
  output logic                           busy,
  output logic                           done,
  output logic [grdfs_pkg::STATUS_W-1:0] status
);
  import grdfs_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EDGE  = 6'b000010,
    S_CHECK = 6'b000100,
    S_ROW   = 6'b001000,
    S_PICK  = 6'b010000,
    S_POP   = 6'b100000
  } state_t;

  state_t                state, state_next;
  logic                  done_next;
  logic [STATUS_W-1:0]   status_next;

  always_comb begin
    cmd         = '0;
    state_next  = state;
    done_next   = 1'b0;
    status_next = status;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (func)
            FUNC_CLEAR: begin
              cmd.clear = 1'b1;
            end
            FUNC_ADD: begin
              if (sts.src_ok && sts.dst_ok) begin
                cmd.load   = 1'b1;
                state_next = S_EDGE;
              end
            end
            FUNC_QUERY: begin
              priority if (!sts.src_ok) begin
                done_next   = 1'b1;
                status_next = ST_NO_ORIGIN;
              end else if (!sts.dst_ok) begin
                done_next   = 1'b1;
                status_next = ST_NO_DEST;
              end else begin
                cmd.load   = 1'b1;
                cmd.init   = 1'b1;
                state_next = S_CHECK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_EDGE: begin
        cmd.row_wr = 1'b1;
        state_next = S_IDLE;
      end
      S_CHECK: begin
        if (sts.top_is_dst) begin
          done_next   = 1'b1;
          status_next = ST_ROUTE;
          state_next  = S_IDLE;
        end else begin
          state_next = S_ROW;
        end
      end
      S_ROW: begin
        cmd.stage1 = 1'b1;
        state_next = S_PICK;
      end
      S_PICK: begin
        priority if (sts.found && !sts.full) begin
          cmd.push   = 1'b1;
          state_next = S_CHECK;
        end else if (sts.found) begin
          cmd.mark   = 1'b1;
          state_next = S_CHECK;
        end else if (sts.last) begin
          cmd.pop     = 1'b1;
          done_next   = 1'b1;
          status_next = ST_NO_ROUTE;
          state_next  = S_IDLE;
        end else begin
          cmd.pop    = 1'b1;
          state_next = S_POP;
        end
      end
      S_POP: begin
        cmd.pop_top = 1'b1;
        state_next  = S_CHECK;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    status <= status_next;
  end

  assign busy = state != S_IDLE;

endmodule

[design/graph_route_exists_dfs.sv]
// Channel   Direction  Handshake             Payload
// input     in         start, busy           func, src_city, dst_city
// result    out        done (one cycle)      status
// config    in         cfg_we                cfg_data (city_count)
//
// An item is taken at a clock edge with start high and busy low.
// A clear or an edge add gives no result.
// A query with an end out of range answers in the next cycle. Otherwise the
// search does a row read and a candidate search for each push, mark or pop,
// and also a stack reload for each pop but the last; the result shows in the
// cycle after the search ends.
// Synchronous reset empties the graph and sets city_count to 64. The result
// is shown for one cycle on done; the receiver cannot stall it.
module graph_route_exists_dfs #(
  parameter int MAX_CITIES = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [grdfs_pkg::FUNC_W-1:0]   func,
  input  logic [grdfs_pkg::CITY_W-1:0]   src_city,
  input  logic [grdfs_pkg::CITY_W-1:0]   dst_city,
  input  logic                           cfg_we,
  input  logic [grdfs_pkg::COUNT_W-1:0]  cfg_data,
  output logic                           done,
  output logic [grdfs_pkg::STATUS_W-1:0] status
);
  import grdfs_pkg::*;

  // The controller sequences each item; the datapath holds the adjacency
  // rows (a memory with one valid bit per row, so a clear resets only those
  // bits), the visited bitmap, the search stack memory and a two-level finder
  // for the lowest-index unvisited neighbor of the node on top of the stack.
  dp_cmd_t cmd;
  dp_sts_t sts;

  grdfs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .func   (func),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .status (status)
  );

  grdfs_datapath #(.N(MAX_CITIES)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .src_city (src_city),
    .dst_city (dst_city),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

[design/grdfs_checker.sv]
module grdfs_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic [grdfs_pkg::FUNC_W-1:0]   func,
  input logic                           done,
  input logic [grdfs_pkg::STATUS_W-1:0] status
);
  import grdfs_pkg::*;

  // A result only comes out while the block is idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // Items other than queries never produce a result.
  a_no_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && func != FUNC_QUERY) |=> !done)
    else $error("result after a non-query item");

  // A query either answers at once or starts a search.
  a_query_moves: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && func == FUNC_QUERY) |=> (done || busy))
    else $error("query neither answered nor started");

  // The block only becomes busy by taking an item.
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && !busy))
    else $error("busy without an accepted item");

  // Every result carries a known status.
  a_status_known: assert property (@(posedge clk) disable iff (rst)
    done |-> !$isunknown(status))
    else $error("result with an unknown status");

endmodule

bind graph_route_exists_dfs grdfs_checker u_grdfs_checker (.*);
